// ----- hw/rtl/pfsp_pkg.sv -----
// Shared types and constants for the playback frame step pacer.
// Used by the channel interfaces and the pacer top level; no dependencies.
package pfsp_pkg;

	// Payload widths
	localparam int OP_W    = 4;
	localparam int VAL_W   = 12;
	localparam int TIME_W  = 32;
	localparam int MODE_W  = 2;
	localparam int SPEED_W = 8;
	localparam int STEP_W  = 9;

	// Configuration widths and register indexes
	localparam int FPS_W    = 18;
	localparam int LIM_W    = 7;
	localparam int CFG_W    = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FPS       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd2;

	localparam logic [FPS_W-1:0] FPS_RESET       = 18'd25000;
	localparam logic [LIM_W-1:0] MAX_SPEED_RESET = 7'd40;
	localparam logic [LIM_W-1:0] MIN_SPEED_RESET = 7'd1;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_PLAY        = 4'd0;
	localparam logic [OP_W-1:0] OP_PAUSE       = 4'd1;
	localparam logic [OP_W-1:0] OP_STOP        = 4'd2;
	localparam logic [OP_W-1:0] OP_TOGGLE      = 4'd3;
	localparam logic [OP_W-1:0] OP_SET_SPEED   = 4'd4;
	localparam logic [OP_W-1:0] OP_ADJUST      = 4'd5;
	localparam logic [OP_W-1:0] OP_RESET_SPEED = 4'd6;
	localparam logic [OP_W-1:0] OP_RESET_CLOCK = 4'd7;
	localparam logic [OP_W-1:0] OP_EOF         = 4'd8;
	localparam logic [OP_W-1:0] OP_TICK        = 4'd9;

	// Run state codes
	localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd2;

	// Speed after reset: 1.0 in fifths
	localparam logic signed [SPEED_W-1:0] SPEED_RESET = 8'sd5;
	localparam int SPEED_MAG_MAX = 127;

	// Frame debt counts 1 us * 1 mHz * 1 fifth; one frame is 5e9 of those
	localparam longint unsigned DEBT_PER_FRAME = 64'd5000000000;
	localparam int DEBT_W = 33;
	localparam longint unsigned FPS_MAX = 64'd262143;

	localparam logic [STEP_W-1:0] STEP_MAX = 9'd511;

	localparam int ELAPSED_LIMIT_US_DEF = 100000;

endpackage

// ----- hw/rtl/pfsp_in_if.sv -----
// Request channel of the frame step pacer: valid/ready plus request payload.
// Depends on pfsp_pkg for field widths.
interface pfsp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [pfsp_pkg::OP_W-1:0]             op;
	logic signed [pfsp_pkg::VAL_W-1:0]     value_hundredths;
	logic [pfsp_pkg::TIME_W-1:0]           time_us;

	modport source (output valid, op, value_hundredths, time_us, input ready);
	modport sink   (input valid, op, value_hundredths, time_us, output ready);
endinterface

// ----- hw/rtl/pfsp_out_if.sv -----
// Result channel of the frame step pacer: valid/ready plus result payload.
// Depends on pfsp_pkg for field widths.
interface pfsp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [pfsp_pkg::MODE_W-1:0]           run_state;
	logic signed [pfsp_pkg::SPEED_W-1:0]   speed_fifths;
	logic [pfsp_pkg::STEP_W-1:0]           step_count;
	logic                                  step_backward;
	logic                                  state_event;
	logic                                  speed_event;
	logic                                  continuous_event;
	logic                                  continuous_value;

	modport source (output valid, run_state, speed_fifths, step_count, step_backward,
		state_event, speed_event, continuous_event, continuous_value, input ready);
	modport sink   (input valid, run_state, speed_fifths, step_count, step_backward,
		state_event, speed_event, continuous_event, continuous_value, output ready);
endinterface

// ----- hw/rtl/playback_frame_step_pacer.sv -----
// Playback frame step pacer top level: play/pause/stop sequencer and frame step pacing.
// Depends on pfsp_pkg, pfsp_in_if and pfsp_out_if.
//
// Usage:
//   cmd carries one request (op, value_hundredths, time_us); res returns exactly one
//   result per request: run state, signed speed in fifths, frame step count with
//   direction, and state / speed / continuous-play event flags.
//   cfg_we/cfg_index/cfg_wdata write frame rate, max and min speed; write only while idle.
// Sequencing:
//   A request is taken only while the sequencer is idle. Play/pause/stop/clock ops
//   and ticks that do nothing go from execute to the done step, where the result
//   register loads; speed ops pass a rounding multiply and a set step, and a tick
//   while playing at nonzero speed two multiplies building the new debt, a reciprocal
//   estimate of whole frames low by at most two, and fix-up cycles that each subtract
//   one more frame. The next request is accepted in the cycle after the result loads.
// Reset:
//   Stopped, speed 1.0, no frame debt, clock start 0, config at its reset values.
// Back-pressure:
//   The result register holds while res.ready is low; the next request can be
//   accepted and processed meanwhile, and waits in the last step for the slot.
module playback_frame_step_pacer #(
	parameter int ELAPSED_LIMIT_US = pfsp_pkg::ELAPSED_LIMIT_US_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfsp_pkg::CFG_W-1:0]         cfg_wdata,
	pfsp_in_if.sink                            cmd,
	pfsp_out_if.source                         res
);

	// Derived widths
	localparam int EL_W = $clog2(ELAPSED_LIMIT_US + 1);
	localparam int P1_W = EL_W + pfsp_pkg::FPS_W;
	localparam int P2_W = P1_W + pfsp_pkg::LIM_W;
	localparam longint unsigned ACC_MAX = pfsp_pkg::DEBT_PER_FRAME - 64'd1
		+ longint'(ELAPSED_LIMIT_US) * pfsp_pkg::FPS_MAX * pfsp_pkg::SPEED_MAG_MAX;
	localparam int ACC_W = $clog2(ACC_MAX + 1);
	localparam int FR_W  = ACC_W - pfsp_pkg::DEBT_W + 1;
	localparam int SAT_W = (FR_W > pfsp_pkg::STEP_W) ? FR_W : pfsp_pkg::STEP_W;
	localparam logic [pfsp_pkg::TIME_W-1:0] EL_LIMIT = pfsp_pkg::TIME_W'(ELAPSED_LIMIT_US);

	// Whole frames: top 24 bits of the debt times 2^ACC_W / 5e9 gives an estimate
	// at most two low; one frame is 9765625 << 9
	localparam int XH_W       = 24;
	localparam int XH_LSB     = ACC_W - XH_W;
	localparam int DEBT_SHIFT = 9;
	localparam int ODD_W      = 24;
	localparam logic [FR_W-1:0] DEBT_RECIP =
		FR_W'((64'd1 << ACC_W) / pfsp_pkg::DEBT_PER_FRAME);
	localparam logic [ODD_W-1:0] DEBT_ODD = ODD_W'(pfsp_pkg::DEBT_PER_FRAME >> DEBT_SHIFT);
	localparam logic [ACC_W-1:0] DEBT_FRAME = ACC_W'(pfsp_pkg::DEBT_PER_FRAME);

	// Speed rounding: hundredths -> fifths as ((|h| + 10) >> 2) / 5 via reciprocal
	localparam int H_W = 14;
	localparam int MAG_W = 13;
	localparam logic signed [H_W-1:0] SPEED_RESET_HUND = 14'sd100;
	localparam logic [MAG_W-1:0] ROUND_HALF = 13'd10;
	localparam logic [11:0] RECIP5 = 12'd3277;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_SPD_MUL, ST_SPD_SET, ST_MUL1, ST_MUL2,
		ST_QEST, ST_QMUL, ST_QSUB, ST_QFIX, ST_DONE
	} state_t;

	state_t state_q;

	// Configuration
	logic [pfsp_pkg::FPS_W-1:0] fps_q;
	logic [pfsp_pkg::LIM_W-1:0] max_q, min_q;

	// Architectural state
	logic [pfsp_pkg::MODE_W-1:0]         mode_q;
	logic signed [pfsp_pkg::SPEED_W-1:0] speed_q;
	logic [pfsp_pkg::DEBT_W-1:0]         debt_q;
	logic [pfsp_pkg::TIME_W-1:0]         clock_q;

	// Latched request
	logic [pfsp_pkg::OP_W-1:0]           op_q;
	logic signed [pfsp_pkg::VAL_W-1:0]   value_q;
	logic [pfsp_pkg::TIME_W-1:0]         time_q;

	// Working registers
	logic [MAG_W-1:0]       hmag_q;
	logic                   hneg_q;
	logic [7:0]             fround_q;
	logic [EL_W-1:0]        el_q;
	logic [P1_W-1:0]        p1_q;
	logic [ACC_W-1:0]       acc_q;
	logic [FR_W-1:0]        quo_q;
	logic [FR_W+ODD_W-1:0]  qd_q;

	// Per-request result bits
	logic                         ev_state_q, ev_speed_q, ev_cont_q, ev_cont_val_q;
	logic [pfsp_pkg::STEP_W-1:0]  steps_q;
	logic                         back_q;

	// Result register
	logic                                res_valid_q;
	logic [pfsp_pkg::MODE_W-1:0]         res_mode_q;
	logic signed [pfsp_pkg::SPEED_W-1:0] res_speed_q;
	logic [pfsp_pkg::STEP_W-1:0]         res_steps_q;
	logic                                res_back_q;
	logic                                res_ev_state_q, res_ev_speed_q;
	logic                                res_ev_cont_q, res_ev_cont_val_q;

	logic cmd_fire;
	logic res_load;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Requested speed in hundredths, sign and magnitude
	logic signed [H_W-1:0] spd14, val14, h_req, h_abs;
	always_comb begin
		spd14 = H_W'(speed_q);
		val14 = H_W'(value_q);
		if (op_q == pfsp_pkg::OP_SET_SPEED) begin
			h_req = val14;
		end else if (op_q == pfsp_pkg::OP_ADJUST) begin
			h_req = (spd14 <<< 4) + (spd14 <<< 2) + val14;
		end else begin
			h_req = SPEED_RESET_HUND;
		end
		h_abs = h_req[H_W-1] ? -h_req : h_req;
	end

	// Divide by 20 with rounding
	logic [MAG_W-1:0] h_round;
	logic [22:0]      recip_prod;
	always_comb begin
		h_round    = hmag_q + ROUND_HALF;
		recip_prod = h_round[MAG_W-1:2] * RECIP5;
	end

	// Clamp to max, zero below min, apply sign
	logic [7:0]                          f_clamp, f_final;
	logic signed [pfsp_pkg::SPEED_W-1:0] speed_new;
	always_comb begin
		f_clamp = (fround_q > {1'b0, max_q}) ? {1'b0, max_q} : fround_q;
		f_final = (f_clamp != 8'd0 && f_clamp < {1'b0, min_q}) ? 8'd0 : f_clamp;
		speed_new = hneg_q ? -f_final : f_final;
	end

	// Elapsed time since the clock start, capped
	logic [pfsp_pkg::TIME_W-1:0] el_diff, el_cap;
	always_comb begin
		el_diff = time_q - clock_q;
		el_cap  = (el_diff > EL_LIMIT) ? EL_LIMIT : el_diff;
	end

	// Speed magnitude and debt product
	logic [pfsp_pkg::LIM_W-1:0] speed_mag;
	logic [pfsp_pkg::SPEED_W-1:0] speed_abs;
	logic [P2_W-1:0] p2;
	always_comb begin
		speed_abs = speed_q[pfsp_pkg::SPEED_W-1] ? -speed_q : speed_q;
		speed_mag = speed_abs[pfsp_pkg::LIM_W-1:0];
		p2        = p1_q * speed_mag;
	end

	// Frame estimate, its debt back-product, fix-up compare and step saturation
	logic [XH_W+FR_W-1:0]        est_prod;
	logic [FR_W+ODD_W-1:0]       qd_next;
	logic                        fix_ge;
	logic [SAT_W-1:0]            quo_ext;
	logic [pfsp_pkg::STEP_W-1:0] steps_sat;
	always_comb begin
		est_prod  = acc_q[ACC_W-1:XH_LSB] * DEBT_RECIP;
		qd_next   = quo_q * DEBT_ODD;
		fix_ge    = (acc_q >= DEBT_FRAME);
		quo_ext   = SAT_W'(quo_q);
		steps_sat = (quo_ext > SAT_W'(pfsp_pkg::STEP_MAX)) ? pfsp_pkg::STEP_MAX
			: quo_ext[pfsp_pkg::STEP_W-1:0];
	end

	// Sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fps_q       <= pfsp_pkg::FPS_RESET;
			max_q       <= pfsp_pkg::MAX_SPEED_RESET;
			min_q       <= pfsp_pkg::MIN_SPEED_RESET;
			mode_q      <= pfsp_pkg::MODE_STOPPED;
			speed_q     <= pfsp_pkg::SPEED_RESET;
			debt_q      <= '0;
			clock_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// config writes
			if (cfg_we) begin
				unique case (cfg_index)
					pfsp_pkg::CFG_FPS:       fps_q <= cfg_wdata[pfsp_pkg::FPS_W-1:0];
					pfsp_pkg::CFG_MAX_SPEED: max_q <= cfg_wdata[pfsp_pkg::LIM_W-1:0];
					pfsp_pkg::CFG_MIN_SPEED: min_q <= cfg_wdata[pfsp_pkg::LIM_W-1:0];
					default: ;
				endcase
			end

			// result slot: load from the done step, free when taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						op_q          <= cmd.op;
						value_q       <= cmd.value_hundredths;
						time_q        <= cmd.time_us;
						ev_state_q    <= 1'b0;
						ev_speed_q    <= 1'b0;
						ev_cont_q     <= 1'b0;
						ev_cont_val_q <= 1'b0;
						steps_q       <= '0;
						back_q        <= 1'b0;
						state_q       <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (op_q)
						pfsp_pkg::OP_PLAY, pfsp_pkg::OP_PAUSE, pfsp_pkg::OP_TOGGLE,
						pfsp_pkg::OP_EOF: begin
							if (mode_q == pfsp_pkg::MODE_PLAYING) begin
								// pause path; plain play while playing does nothing
								if (op_q != pfsp_pkg::OP_PLAY) begin
									mode_q        <= pfsp_pkg::MODE_PAUSED;
									ev_cont_q     <= 1'b1;
									ev_cont_val_q <= 1'b0;
									ev_state_q    <= 1'b1;
								end
							end else if (op_q == pfsp_pkg::OP_PLAY ||
								op_q == pfsp_pkg::OP_TOGGLE) begin
								mode_q        <= pfsp_pkg::MODE_PLAYING;
								debt_q        <= '0;
								clock_q       <= time_q;
								ev_cont_q     <= 1'b1;
								ev_cont_val_q <= (speed_q > 0);
								ev_state_q    <= 1'b1;
							end
						end
						pfsp_pkg::OP_STOP: begin
							mode_q        <= pfsp_pkg::MODE_STOPPED;
							debt_q        <= '0;
							ev_cont_q     <= 1'b1;
							ev_cont_val_q <= 1'b0;
							ev_state_q    <= 1'b1;
						end
						pfsp_pkg::OP_SET_SPEED, pfsp_pkg::OP_ADJUST,
						pfsp_pkg::OP_RESET_SPEED: begin
							hmag_q  <= h_abs[MAG_W-1:0];
							hneg_q  <= h_req[H_W-1];
							state_q <= ST_SPD_MUL;
						end
						pfsp_pkg::OP_RESET_CLOCK: begin
							debt_q  <= '0;
							clock_q <= time_q;
						end
						pfsp_pkg::OP_TICK: begin
							if (mode_q == pfsp_pkg::MODE_PLAYING && speed_q != 0) begin
								el_q    <= el_cap[EL_W-1:0];
								clock_q <= time_q;
								state_q <= ST_MUL1;
							end
						end
						default: ;
					endcase
				end

				ST_SPD_MUL: begin
					fround_q <= recip_prod[21:14];
					state_q  <= ST_SPD_SET;
				end

				ST_SPD_SET: begin
					if (speed_new != speed_q) begin
						speed_q    <= speed_new;
						debt_q     <= '0;
						ev_speed_q <= 1'b1;
						if (mode_q == pfsp_pkg::MODE_PLAYING &&
							((speed_new > 0) != (speed_q > 0))) begin
							ev_cont_q     <= 1'b1;
							ev_cont_val_q <= (speed_new > 0);
						end
					end
					state_q <= ST_DONE;
				end

				ST_MUL1: begin
					p1_q    <= el_q * fps_q;
					state_q <= ST_MUL2;
				end

				ST_MUL2: begin
					acc_q   <= ACC_W'(debt_q) + ACC_W'(p2);
					state_q <= ST_QEST;
				end

				// whole frames, estimated low by at most two
				ST_QEST: begin
					quo_q   <= est_prod[XH_W+FR_W-1:XH_W];
					state_q <= ST_QMUL;
				end

				ST_QMUL: begin
					qd_q    <= qd_next;
					state_q <= ST_QSUB;
				end

				ST_QSUB: begin
					acc_q   <= acc_q - ACC_W'({qd_q, {DEBT_SHIFT{1'b0}}});
					state_q <= ST_QFIX;
				end

				// one more frame per cycle until the debt is below a frame
				ST_QFIX: begin
					if (fix_ge) begin
						acc_q <= acc_q - DEBT_FRAME;
						quo_q <= quo_q + 1'b1;
					end else begin
						debt_q <= acc_q[pfsp_pkg::DEBT_W-1:0];
						if (quo_q != '0) begin
							steps_q <= steps_sat;
							back_q  <= speed_q[pfsp_pkg::SPEED_W-1];
						end
						state_q <= ST_DONE;
					end
				end

				ST_DONE: begin
					if (res_load) begin
						res_mode_q        <= mode_q;
						res_speed_q       <= speed_q;
						res_steps_q       <= steps_q;
						res_back_q        <= back_q;
						res_ev_state_q    <= ev_state_q;
						res_ev_speed_q    <= ev_speed_q;
						res_ev_cont_q     <= ev_cont_q;
						res_ev_cont_val_q <= ev_cont_val_q;
						state_q           <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid            = res_valid_q;
	assign res.run_state        = res_mode_q;
	assign res.speed_fifths     = res_speed_q;
	assign res.step_count       = res_steps_q;
	assign res.step_backward    = res_back_q;
	assign res.state_event      = res_ev_state_q;
	assign res.speed_event      = res_ev_speed_q;
	assign res.continuous_event = res_ev_cont_q;
	assign res.continuous_value = res_ev_cont_val_q;

endmodule
